// ----- hw/rtl/scalar_to_rgb_colormap_core_assert.svh -----
// Assertion macros for the colour map core checker.
// STC_ASSERT: clocked check, switched off while reset is high.
// STC_ASSERT_RST: clocked check that also holds during reset.
`ifndef SCALAR_TO_RGB_COLORMAP_CORE_ASSERT_SVH
`define SCALAR_TO_RGB_COLORMAP_CORE_ASSERT_SVH

`define STC_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("colour map core: assertion failed");

`define STC_ASSERT_RST(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("colour map core: reset assertion failed");

`endif

// ----- hw/rtl/stc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stc_pkg
// Shared types and constants of the scalar to RGB colour map core.
// ----------------------------------------------------------------------------
package stc_pkg;

  localparam int STC_SAMPLE_BITS   = 16;
  localparam int STC_FRACTION_BITS = 16;
  localparam int COLOR_W           = 8;

  // configuration register indexes
  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] REG_RANGE_MIN  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_RANGE_MAX  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_MAP_SELECT = 2'd2;

  // reset values, truncated to the sample width where used
  localparam logic signed [31:0] RANGE_MIN_RESET = -32'sd32768;
  localparam logic signed [31:0] RANGE_MAX_RESET = 32'sd32767;

  // sample classes
  localparam logic [1:0] CLS_BELOW = 2'd0;
  localparam logic [1:0] CLS_ABOVE = 2'd1;
  localparam logic [1:0] CLS_RAMP  = 2'd2;

  // segment numbers
  localparam int SEG_W = 3;
  localparam logic [SEG_W-1:0] SEG1 = 3'd1;
  localparam logic [SEG_W-1:0] SEG2 = 3'd2;
  localparam logic [SEG_W-1:0] SEG3 = 3'd3;
  localparam logic [SEG_W-1:0] SEG4 = 3'd4;
  localparam logic [SEG_W-1:0] SEG5 = 3'd5;
  localparam logic [SEG_W-1:0] SEG6 = 3'd6;

  localparam logic [COLOR_W-1:0] COLOR_MAX  = 8'd255;
  localparam logic [COLOR_W-1:0] COLOR_HALF = 8'd128;
  localparam logic [COLOR_W-1:0] COLOR_OFF  = 8'd0;

  typedef struct packed {
    logic [1:0] cls;
    logic       sym;
  } stc_ctrl_t;

endpackage

// ----- hw/rtl/stc_sample_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stc_sample_if
// Valid/ready channel carrying one signed sample per transaction.
// ----------------------------------------------------------------------------
interface stc_sample_if import stc_pkg::*; #(
  parameter int WIDTH = STC_SAMPLE_BITS
);
  logic             valid;
  logic             ready;
  logic [WIDTH-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

// ----- hw/rtl/stc_rgb_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stc_rgb_if
// Valid/ready channel carrying one RGB byte triple per transaction.
// ----------------------------------------------------------------------------
interface stc_rgb_if import stc_pkg::*;;
  logic               valid;
  logic               ready;
  logic [COLOR_W-1:0] red;
  logic [COLOR_W-1:0] green;
  logic [COLOR_W-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

// ----- hw/rtl/stc_prep.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stc_prep
// Front stage: offset and span against the range, and sample class.
// ----------------------------------------------------------------------------
module stc_prep import stc_pkg::*; #(
  parameter int SAMPLE_BITS = STC_SAMPLE_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   up_valid,
  output logic                   up_ready,
  input  logic [SAMPLE_BITS-1:0] sample,
  input  logic [SAMPLE_BITS-1:0] range_min,
  input  logic [SAMPLE_BITS-1:0] range_max,
  input  logic                   map_select,
  output logic                   dn_valid,
  input  logic                   dn_ready,
  output logic [SAMPLE_BITS-1:0] offset,
  output logic [SAMPLE_BITS-1:0] span,
  output stc_ctrl_t              ctrl
);

  logic signed [SAMPLE_BITS:0] diff;
  logic signed [SAMPLE_BITS:0] width;
  logic                        diff_pos;
  logic                        width_pos;
  logic [1:0]                  cls;

  assign diff  = $signed({sample[SAMPLE_BITS-1], sample})
               - $signed({range_min[SAMPLE_BITS-1], range_min});
  assign width = $signed({range_max[SAMPLE_BITS-1], range_max})
               - $signed({range_min[SAMPLE_BITS-1], range_min});

  assign diff_pos  = !diff[SAMPLE_BITS] && (diff != '0);
  assign width_pos = !width[SAMPLE_BITS] && (width != '0);

  always_comb begin
    if (!width_pos) begin
      // empty or inverted range
      cls = diff_pos ? CLS_ABOVE : CLS_BELOW;
    end else if (diff > width) begin
      cls = CLS_ABOVE;
    end else if (!diff_pos) begin
      cls = CLS_BELOW;
    end else begin
      cls = CLS_RAMP;
    end
  end

  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      offset   <= diff[SAMPLE_BITS-1:0];
      span     <= width[SAMPLE_BITS-1:0];
      ctrl.cls <= cls;
      ctrl.sym <= map_select;
    end
  end

endmodule

// ----- hw/rtl/stc_div_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stc_div_cell
// One restoring divider cell: a trial subtract yielding one quotient bit.
// ----------------------------------------------------------------------------
module stc_div_cell import stc_pkg::*; #(
  parameter int SAMPLE_BITS   = STC_SAMPLE_BITS,
  parameter int FRACTION_BITS = STC_FRACTION_BITS,
  parameter bit SHIFT         = 1'b1
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     up_valid,
  output logic                     up_ready,
  input  logic [SAMPLE_BITS:0]     rem_in,
  input  logic [SAMPLE_BITS-1:0]   span_in,
  input  logic [FRACTION_BITS:0]   quot_in,
  input  stc_ctrl_t                ctrl_in,
  output logic                     dn_valid,
  input  logic                     dn_ready,
  output logic [SAMPLE_BITS:0]     rem_out,
  output logic [SAMPLE_BITS-1:0]   span_out,
  output logic [FRACTION_BITS:0]   quot_out,
  output stc_ctrl_t                ctrl_out
);

  logic [SAMPLE_BITS:0] trial;
  logic [SAMPLE_BITS:0] span_ext;
  logic                 fits;

  // remainder stays below span, so doubling never overflows
  assign trial    = SHIFT ? {rem_in[SAMPLE_BITS-1:0], 1'b0} : rem_in;
  assign span_ext = {1'b0, span_in};
  assign fits     = (trial >= span_ext);

  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      rem_out  <= fits ? (trial - span_ext) : trial;
      span_out <= span_in;
      quot_out <= {quot_in[FRACTION_BITS-1:0], fits};
      ctrl_out <= ctrl_in;
    end
  end

endmodule

// ----- hw/rtl/stc_segment.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stc_segment
// Picks the sixth of the scale that holds t and the ramp position in it.
// ----------------------------------------------------------------------------
module stc_segment import stc_pkg::*; #(
  parameter int FRACTION_BITS = STC_FRACTION_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   up_valid,
  output logic                   up_ready,
  input  logic [FRACTION_BITS:0] quot,
  input  stc_ctrl_t              ctrl_in,
  output logic                   dn_valid,
  input  logic                   dn_ready,
  output logic [SEG_W-1:0]       seg,
  output logic [FRACTION_BITS:0] ramp,
  output stc_ctrl_t              ctrl_out
);

  localparam int SIX_W = FRACTION_BITS + 3;

  logic [SIX_W-1:0] six;
  logic [SEG_W-1:0] seg_m1;
  logic [SIX_W-1:0] base;
  logic [SIX_W-1:0] ramp_full;
  stc_ctrl_t        ctrl;

  assign six = {quot, 2'b00} + {1'b0, quot, 1'b0};

  // ties at a boundary stay in the lower segment
  always_comb begin
    seg_m1 = '0;
    for (int k = 1; k < 6; k++) begin
      if (six > (SIX_W'(k) << FRACTION_BITS)) begin
        seg_m1 = seg_m1 + SEG_W'(1);
      end
    end
  end

  assign base      = SIX_W'(seg_m1) << FRACTION_BITS;
  assign ramp_full = six - base;

  always_comb begin
    ctrl = ctrl_in;
    if (ctrl_in.cls == CLS_RAMP && quot == '0) begin
      ctrl.cls = CLS_BELOW;
    end
  end

  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      seg      <= seg_m1 + SEG_W'(1);
      ramp     <= ramp_full[FRACTION_BITS:0];
      ctrl_out <= ctrl;
    end
  end

endmodule

// ----- hw/rtl/stc_shade.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stc_shade
// Ramp to colour bytes, map selection and the output register.
// ----------------------------------------------------------------------------
module stc_shade import stc_pkg::*; #(
  parameter int FRACTION_BITS = STC_FRACTION_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   up_valid,
  output logic                   up_ready,
  input  logic [SEG_W-1:0]       seg,
  input  logic [FRACTION_BITS:0] ramp,
  input  stc_ctrl_t              ctrl,
  output logic                   dn_valid,
  input  logic                   dn_ready,
  output logic [COLOR_W-1:0]     red,
  output logic [COLOR_W-1:0]     green,
  output logic [COLOR_W-1:0]     blue
);

  localparam int P_W = FRACTION_BITS + 10;
  localparam logic [FRACTION_BITS+1:0] ONE = (FRACTION_BITS+2)'(1) << FRACTION_BITS;

  logic [FRACTION_BITS+1:0] ramp_ext;
  logic [P_W-1:0]           rise_p;
  logic [P_W-1:0]           fall_p;
  logic [P_W-1:0]           up_p;
  logic [P_W-1:0]           down_p;
  logic [COLOR_W-1:0]       rise;
  logic [COLOR_W-1:0]       fall;
  logic [COLOR_W-1:0]       half_up;
  logic [COLOR_W-1:0]       half_down;
  logic [COLOR_W-1:0]       r_next;
  logic [COLOR_W-1:0]       g_next;
  logic [COLOR_W-1:0]       b_next;

  assign ramp_ext = {1'b0, ramp};

  // exact truncation of 255 * fraction, ramp lies in [0, ONE]
  assign rise_p = P_W'(ramp_ext) * P_W'(COLOR_MAX);
  assign fall_p = P_W'(ONE - ramp_ext) * P_W'(COLOR_MAX);
  assign up_p   = P_W'(ramp_ext + ONE) * P_W'(COLOR_MAX);
  assign down_p = P_W'((ONE << 1) - ramp_ext) * P_W'(COLOR_MAX);

  assign rise      = rise_p[FRACTION_BITS +: COLOR_W];
  assign fall      = fall_p[FRACTION_BITS +: COLOR_W];
  assign half_up   = up_p[FRACTION_BITS+1 +: COLOR_W];
  assign half_down = down_p[FRACTION_BITS+1 +: COLOR_W];

  always_comb begin
    r_next = COLOR_OFF;
    g_next = COLOR_OFF;
    b_next = COLOR_OFF;
    if (ctrl.cls == CLS_BELOW) begin
      b_next = COLOR_HALF;
    end else if (ctrl.cls == CLS_ABOVE) begin
      if (ctrl.sym) begin
        r_next = COLOR_HALF;
      end else begin
        r_next = COLOR_MAX;
        g_next = COLOR_MAX;
        b_next = COLOR_MAX;
      end
    end else begin
      case (seg)
        SEG1: begin
          b_next = half_up;
        end
        SEG2: begin
          g_next = rise;
          b_next = COLOR_MAX;
        end
        SEG3: begin
          r_next = ctrl.sym ? rise : COLOR_OFF;
          g_next = COLOR_MAX;
          b_next = ctrl.sym ? COLOR_MAX : fall;
        end
        SEG4: begin
          r_next = ctrl.sym ? COLOR_MAX : rise;
          g_next = COLOR_MAX;
          b_next = ctrl.sym ? fall : COLOR_OFF;
        end
        SEG5: begin
          r_next = COLOR_MAX;
          g_next = fall;
        end
        default: begin
          r_next = ctrl.sym ? half_down : COLOR_MAX;
          g_next = ctrl.sym ? COLOR_OFF : rise;
          b_next = ctrl.sym ? COLOR_OFF : rise;
        end
      endcase
    end
  end

  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      red   <= r_next;
      green <= g_next;
      blue  <= b_next;
    end
  end

endmodule

// ----- hw/rtl/scalar_to_rgb_colormap_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scalar_to_rgb_colormap_core
// Colours signed samples with the jet or the symmetric blue-white-red map.
// ----------------------------------------------------------------------------
//  channel  | dir | payload            | handshake
//  samples  | in  | sample             | valid / ready
//  pixels   | out | red, green, blue   | valid / ready
//  cfg      | in  | cfg_index, cfg_data| cfg_write, no back-pressure
//
// One transaction per clock sustained while the output is not stalled. Stages:
// front stage, FRACTION_BITS + 1 divider cells, segment stage, output stage.
// The divider chain sets the latency; every stage holds one transaction.
// Each stage has its own valid bit, so bubbles close up behind a stalled output.
// Synchronous reset empties the pipeline and loads the default range.
// ----------------------------------------------------------------------------
module scalar_to_rgb_colormap_core import stc_pkg::*; #(
  parameter int FRACTION_BITS = STC_FRACTION_BITS
) (
  input  logic                       clk,
  input  logic                       rst,
  stc_sample_if.sink                 samples,
  stc_rgb_if.source                  pixels,
  input  logic                       cfg_write,
  input  logic [CFG_INDEX_W-1:0]     cfg_index,
  input  logic [STC_SAMPLE_BITS-1:0] cfg_data
);

  // sample width follows the channel interface
  localparam int SAMPLE_BITS = STC_SAMPLE_BITS;
  localparam int CELLS       = FRACTION_BITS + 1;

  logic [SAMPLE_BITS-1:0] range_min;
  logic [SAMPLE_BITS-1:0] range_max;
  logic                   map_select;

  always_ff @(posedge clk) begin
    if (rst) begin
      range_min  <= RANGE_MIN_RESET[SAMPLE_BITS-1:0];
      range_max  <= RANGE_MAX_RESET[SAMPLE_BITS-1:0];
      map_select <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_RANGE_MIN:  range_min  <= cfg_data;
        REG_RANGE_MAX:  range_max  <= cfg_data;
        REG_MAP_SELECT: map_select <= cfg_data[0];
        default: ;
      endcase
    end
  end

  logic                   chain_valid [CELLS+1];
  logic                   chain_ready [CELLS+1];
  logic [SAMPLE_BITS:0]   chain_rem   [CELLS+1];
  logic [SAMPLE_BITS-1:0] chain_span  [CELLS+1];
  logic [FRACTION_BITS:0] chain_quot  [CELLS+1];
  stc_ctrl_t              chain_ctrl  [CELLS+1];
  logic [SAMPLE_BITS-1:0] offset;

  stc_prep #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_prep (
    .clk        (clk),
    .rst        (rst),
    .up_valid   (samples.valid),
    .up_ready   (samples.ready),
    .sample     (samples.sample),
    .range_min  (range_min),
    .range_max  (range_max),
    .map_select (map_select),
    .dn_valid   (chain_valid[0]),
    .dn_ready   (chain_ready[0]),
    .offset     (offset),
    .span       (chain_span[0]),
    .ctrl       (chain_ctrl[0])
  );

  assign chain_rem[0]  = {1'b0, offset};
  assign chain_quot[0] = '0;

  // first cell tests offset against span directly for the integer bit
  for (genvar i = 0; i < CELLS; i++) begin : g_div
    stc_div_cell #(
      .SAMPLE_BITS   (SAMPLE_BITS),
      .FRACTION_BITS (FRACTION_BITS),
      .SHIFT         (i != 0)
    ) u_div (
      .clk      (clk),
      .rst      (rst),
      .up_valid (chain_valid[i]),
      .up_ready (chain_ready[i]),
      .rem_in   (chain_rem[i]),
      .span_in  (chain_span[i]),
      .quot_in  (chain_quot[i]),
      .ctrl_in  (chain_ctrl[i]),
      .dn_valid (chain_valid[i+1]),
      .dn_ready (chain_ready[i+1]),
      .rem_out  (chain_rem[i+1]),
      .span_out (chain_span[i+1]),
      .quot_out (chain_quot[i+1]),
      .ctrl_out (chain_ctrl[i+1])
    );
  end

  logic                   seg_valid;
  logic                   seg_ready;
  logic [SEG_W-1:0]       seg;
  logic [FRACTION_BITS:0] ramp;
  stc_ctrl_t              seg_ctrl;

  stc_segment #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_segment (
    .clk      (clk),
    .rst      (rst),
    .up_valid (chain_valid[CELLS]),
    .up_ready (chain_ready[CELLS]),
    .quot     (chain_quot[CELLS]),
    .ctrl_in  (chain_ctrl[CELLS]),
    .dn_valid (seg_valid),
    .dn_ready (seg_ready),
    .seg      (seg),
    .ramp     (ramp),
    .ctrl_out (seg_ctrl)
  );

  stc_shade #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_shade (
    .clk      (clk),
    .rst      (rst),
    .up_valid (seg_valid),
    .up_ready (seg_ready),
    .seg      (seg),
    .ramp     (ramp),
    .ctrl     (seg_ctrl),
    .dn_valid (pixels.valid),
    .dn_ready (pixels.ready),
    .red      (pixels.red),
    .green    (pixels.green),
    .blue     (pixels.blue)
  );

endmodule

// ----- hw/rtl/stc_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stc_checker
// Port-level checks of the colour map core, bound to the top level.
// ----------------------------------------------------------------------------
`include "scalar_to_rgb_colormap_core_assert.svh"

module stc_checker import stc_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [COLOR_W-1:0] red,
  input logic [COLOR_W-1:0] green,
  input logic [COLOR_W-1:0] blue
);

  logic [7:0] pending;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // transactions taken in but not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 8'(in_acc) - 8'(out_acc);
    end
  end

  `STC_ASSERT(a_out_hold, clk, rst, (out_valid && !out_ready) |=> out_valid)
  `STC_ASSERT(a_out_stable, clk, rst, (out_valid && !out_ready) |=> $stable({red, green, blue}))
  `STC_ASSERT_RST(a_reset_empty, clk, rst |=> !out_valid)
  `STC_ASSERT(a_no_phantom, clk, rst, out_valid |-> (pending != 8'd0))

endmodule

bind scalar_to_rgb_colormap_core stc_checker u_stc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (samples.valid),
  .in_ready  (samples.ready),
  .out_valid (pixels.valid),
  .out_ready (pixels.ready),
  .red       (pixels.red),
  .green     (pixels.green),
  .blue      (pixels.blue)
);

// ----- test/stc_colour_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stc_colour_checker
// Watches the sample, pixel and register ports of the colour map core. Keeps
// its own copy of the range and map registers, works out the colour of every
// accepted sample and compares each returned pixel with the oldest colour
// still owed, field by field.
// ----------------------------------------------------------------------------
module stc_colour_checker import stc_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  stc_sample_if                      samples,
  stc_rgb_if                         pixels,
  input  logic                       cfg_write,
  input  logic [CFG_INDEX_W-1:0]     cfg_index,
  input  logic [STC_SAMPLE_BITS-1:0] cfg_data,
  output int                         mismatches,
  output int                         pending
);

  localparam int SAMPLE_W = STC_SAMPLE_BITS;

  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } rgb_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    rgb_t                colour;
  } owed_pixel_t;

  logic [SAMPLE_W-1:0] range_lo;
  logic [SAMPLE_W-1:0] range_hi;
  logic                sym_map;
  owed_pixel_t         owed_pixels[$];
  int                  fail_total = 0;

  assign mismatches = fail_total;

  function automatic rgb_t rgb(input logic [COLOR_W-1:0] r, g, b);
    rgb_t c;
    c.red   = r;
    c.green = g;
    c.blue  = b;
    return c;
  endfunction

  // truncated 255 * num / den
  function automatic logic [COLOR_W-1:0] scaled(input longint unsigned num, den);
    return COLOR_W'((64'd255 * num) / den);
  endfunction

  function automatic rgb_t map_colour(input logic [SAMPLE_W-1:0] smp, lo_r, hi_r,
                                      input logic sym);
    longint             s_v, lo_v, hi_v, offset, span;
    longint unsigned    one, q, six, seg, ramp;
    logic [COLOR_W-1:0] rise, fall;
    rgb_t               c;
    s_v    = $signed(smp);
    lo_v   = $signed(lo_r);
    hi_v   = $signed(hi_r);
    offset = s_v - lo_v;
    span   = hi_v - lo_v;
    one    = 64'd1 << STC_FRACTION_BITS;
    // empty or inverted range: anything above the bottom counts as above range
    if (span <= 0 || offset > span) begin
      if (span <= 0 && offset <= 0)
        c = rgb(COLOR_OFF, COLOR_OFF, COLOR_HALF);
      else if (sym)
        c = rgb(COLOR_HALF, COLOR_OFF, COLOR_OFF);
      else
        c = rgb(COLOR_MAX, COLOR_MAX, COLOR_MAX);
      return c;
    end
    if (offset <= 0)
      return rgb(COLOR_OFF, COLOR_OFF, COLOR_HALF);
    q = (64'(offset) << STC_FRACTION_BITS) / 64'(span);
    if (q == 0)
      return rgb(COLOR_OFF, COLOR_OFF, COLOR_HALF);
    // ties on a segment boundary stay in the lower segment
    six = 6 * q;
    seg = 1;
    while (seg < 6 && six > seg * one)
      seg++;
    ramp = six - (seg - 1) * one;
    rise = scaled(ramp, one);
    fall = scaled(one - ramp, one);
    case (seg[SEG_W-1:0])
      SEG1: c = rgb(COLOR_OFF, COLOR_OFF, scaled(ramp + one, 2 * one));
      SEG2: c = rgb(COLOR_OFF, rise, COLOR_MAX);
      SEG3: c = sym ? rgb(rise, COLOR_MAX, COLOR_MAX) : rgb(COLOR_OFF, COLOR_MAX, fall);
      SEG4: c = sym ? rgb(COLOR_MAX, COLOR_MAX, fall) : rgb(rise, COLOR_MAX, COLOR_OFF);
      SEG5: c = rgb(COLOR_MAX, fall, COLOR_OFF);
      default: c = sym ? rgb(scaled(2 * one - ramp, 2 * one), COLOR_OFF, COLOR_OFF)
                       : rgb(COLOR_MAX, rise, rise);
    endcase
    return c;
  endfunction

  task automatic report_mismatch(input string msg);
    fail_total++;
    $display("%0t colour mismatch: %s", $realtime, msg);
  endtask

  task automatic check_field(input string name, input logic [COLOR_W-1:0] got, want,
                             input logic [SAMPLE_W-1:0] smp);
    if (got !== want)
      report_mismatch($sformatf("%s is %0d, expected %0d for sample %0d",
                                name, got, want, $signed(smp)));
  endtask

  always @(posedge clk) begin : watch
    owed_pixel_t owed;
    if (rst) begin
      range_lo = SAMPLE_W'(RANGE_MIN_RESET);
      range_hi = SAMPLE_W'(RANGE_MAX_RESET);
      sym_map  = 1'b0;
      owed_pixels.delete();
    end else begin
      if (pixels.valid && pixels.ready) begin
        if (owed_pixels.size() == 0) begin
          report_mismatch($sformatf("pixel %0d/%0d/%0d with no sample outstanding",
                                    pixels.red, pixels.green, pixels.blue));
        end else begin
          owed = owed_pixels.pop_front();
          check_field("red", pixels.red, owed.colour.red, owed.sample);
          check_field("green", pixels.green, owed.colour.green, owed.sample);
          check_field("blue", pixels.blue, owed.colour.blue, owed.sample);
        end
      end
      // a sample sees the registers as they stood before this edge
      if (samples.valid && samples.ready) begin
        owed.sample = samples.sample;
        owed.colour = map_colour(samples.sample, range_lo, range_hi, sym_map);
        owed_pixels.push_back(owed);
      end
      if (cfg_write) begin
        case (cfg_index)
          REG_RANGE_MIN:  range_lo = cfg_data;
          REG_RANGE_MAX:  range_hi = cfg_data;
          REG_MAP_SELECT: sym_map  = cfg_data[0];
          default: ;
        endcase
      end
    end
    pending <= owed_pixels.size();
  end

endmodule

// ----- test/tb_scalar_to_rgb_colormap_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_scalar_to_rgb_colormap_core
// Streams samples through the colour map core under a series of range and map
// settings: a directed set covering range ends, boundary ties, empty and
// inverted ranges and both maps, then random settings with mostly in-range
// samples. Send bursts and receive stalls vary per random setting; the checker
// beside the core owns all comparisons.
// ----------------------------------------------------------------------------
module tb_scalar_to_rgb_colormap_core;
  import stc_pkg::*;

  localparam int LATENCY     = STC_FRACTION_BITS + 4;
  localparam int QUIET_LIMIT = 2000;
  localparam int PHASES      = 12;
  localparam int PHASE_ITEMS = 120;
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

  typedef enum logic [1:0] {SINK_OPEN, SINK_CHOPPY, SINK_SLOW} sink_mode_e;

  logic                       clk;
  logic                       rst;
  logic                       cfg_write;
  logic [CFG_INDEX_W-1:0]     cfg_index;
  logic [STC_SAMPLE_BITS-1:0] cfg_data;
  int                         mismatches;
  int                         pending;

  sink_mode_e sink_mode    = SINK_OPEN;
  int         ready_hold   = 0;
  int         quiet_cycles = 0;
  int         burst_left   = 0;
  int         burst_max    = 8;
  int         gap_max      = 4;

  stc_sample_if samples_ch ();
  stc_rgb_if    pixels_ch ();

  scalar_to_rgb_colormap_core u_top (
    .clk       (clk),
    .rst       (rst),
    .samples   (samples_ch),
    .pixels    (pixels_ch),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  stc_colour_checker u_check (
    .clk        (clk),
    .rst        (rst),
    .samples    (samples_ch),
    .pixels     (pixels_ch),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver back-pressure, held for a random number of cycles at a time
  always @(posedge clk) begin
    if (rst) begin
      pixels_ch.ready <= 1'b0;
      ready_hold      <= 0;
    end else if (ready_hold == 0) begin
      case (sink_mode)
        SINK_OPEN: begin
          pixels_ch.ready <= 1'b1;
          ready_hold      <= 15;
        end
        SINK_CHOPPY: begin
          pixels_ch.ready <= 1'($urandom_range(0, 1));
          ready_hold      <= $urandom_range(0, 2);
        end
        default: begin
          pixels_ch.ready <= ($urandom_range(0, 3) == 0);
          ready_hold      <= $urandom_range(0, 7);
        end
      endcase
    end else begin
      ready_hold <= ready_hold - 1;
    end
  end

  // watchdog: too long without any transaction on either channel
  always @(posedge clk) begin
    if (rst || (samples_ch.valid && samples_ch.ready) || (pixels_ch.valid && pixels_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_scalar_to_rgb_colormap_core NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_sample(input logic [STC_SAMPLE_BITS-1:0] value);
    int gap;
    if (burst_left == 0) begin
      gap = (gap_max == 0 || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, gap_max);
      if (gap > 0) begin
        samples_ch.valid  <= 1'b0;
        samples_ch.sample <= STC_SAMPLE_BITS'($urandom);
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, burst_max);
    end
    samples_ch.valid  <= 1'b1;
    samples_ch.sample <= value;
    do @(posedge clk); while (!samples_ch.ready);
    burst_left--;
  endtask

  // stop sending and let the pipeline empty before touching the registers
  task automatic settle();
    samples_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic load_setting(input int lo, hi, input logic sym, input logic poke_unused);
    logic [STC_SAMPLE_BITS-1:0] sel_word;
    // upper bits of the map select word are junk on purpose
    sel_word    = STC_SAMPLE_BITS'($urandom);
    sel_word[0] = sym;
    cfg_write <= 1'b1;
    cfg_index <= REG_RANGE_MIN;
    cfg_data  <= STC_SAMPLE_BITS'(lo);
    @(posedge clk);
    cfg_index <= REG_RANGE_MAX;
    cfg_data  <= STC_SAMPLE_BITS'(hi);
    @(posedge clk);
    cfg_index <= REG_MAP_SELECT;
    cfg_data  <= sel_word;
    @(posedge clk);
    if (poke_unused) begin
      cfg_index <= REG_UNUSED;
      cfg_data  <= STC_SAMPLE_BITS'($urandom);
      @(posedge clk);
    end
    cfg_write <= 1'b0;
  endtask

  task automatic choose_pace();
    burst_max  = $urandom_range(1, 48);
    gap_max    = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
    burst_left = 0;
    sink_mode <= sink_mode_e'($urandom_range(0, 2));
  endtask

  task automatic pick_setting(output int lo, hi, output logic sym);
    int a, b;
    case ($urandom_range(0, 9))
      0: begin lo = -32768; hi = 32767; end
      1: begin lo = 32767; hi = -32768; end
      2: begin
        lo = int'($urandom_range(0, 65535)) - 32768;
        hi = lo - int'($urandom_range(0, 3));
        if (hi < -32768) hi = lo;
      end
      3, 4, 5: begin
        // narrow span of 1 to 24, so a handful of samples covers it
        lo = int'($urandom_range(0, 65535 - 24)) - 32768;
        hi = lo + int'($urandom_range(1, 24));
      end
      default: begin
        a  = int'($urandom_range(0, 65535)) - 32768;
        b  = int'($urandom_range(0, 65535)) - 32768;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
      end
    endcase
    sym = 1'($urandom_range(0, 1));
  endtask

  function automatic logic [STC_SAMPLE_BITS-1:0] pick_sample(input int lo, hi);
    int s;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      s = int'($urandom_range(0, 65535)) - 32768;
    end else if (pick < 25) begin
      case ($urandom_range(0, 5))
        0: s = -32768;
        1: s = 32767;
        2: s = lo;
        3: s = lo + 1;
        4: s = hi;
        default: s = hi + 1;
      endcase
    end else if (hi > lo) begin
      s = lo + int'($urandom_range(0, hi - lo + 1));
    end else begin
      s = lo + int'($urandom_range(0, 6)) - 3;
    end
    if (s < -32768) s = -32768;
    else if (s > 32767) s = 32767;
    return STC_SAMPLE_BITS'(s);
  endfunction

  initial begin
    int   full_span[6] = '{-32768, -32767, -1, 0, 32766, 32767};
    int   two_span[5]  = '{-1, 0, 1, 2, 3};
    int   flat_span[3] = '{4, 5, 6};
    int   flip_span[4] = '{-32768, 100, 101, 32767};
    int   span_ends[3] = '{-32768, 0, 32767};
    int   lo, hi;
    logic sym;

    rst               <= 1'b1;
    samples_ch.valid  <= 1'b0;
    samples_ch.sample <= '0;
    cfg_write         <= 1'b0;
    cfg_index         <= REG_RANGE_MIN;
    cfg_data          <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // reset range, jet map
    choose_pace();
    foreach (full_span[i]) send_sample(STC_SAMPLE_BITS'(full_span[i]));
    // span of two: the midpoint lands exactly on a segment boundary
    settle();
    load_setting(0, 2, 1'b0, 1'b0);
    foreach (two_span[i]) send_sample(STC_SAMPLE_BITS'(two_span[i]));
    settle();
    load_setting(0, 2, 1'b1, 1'b1);
    foreach (two_span[i]) send_sample(STC_SAMPLE_BITS'(two_span[i]));
    // empty range
    settle();
    load_setting(5, 5, 1'b1, 1'b0);
    foreach (flat_span[i]) send_sample(STC_SAMPLE_BITS'(flat_span[i]));
    // inverted range
    settle();
    load_setting(100, -100, 1'b0, 1'b0);
    foreach (flip_span[i]) send_sample(STC_SAMPLE_BITS'(flip_span[i]));
    settle();
    load_setting(-32768, 32767, 1'b1, 1'b1);
    foreach (span_ends[i]) send_sample(STC_SAMPLE_BITS'(span_ends[i]));

    for (int phase = 0; phase < PHASES; phase++) begin
      pick_setting(lo, hi, sym);
      settle();
      load_setting(lo, hi, sym, $urandom_range(0, 3) == 0);
      choose_pace();
      repeat (PHASE_ITEMS) send_sample(pick_sample(lo, hi));
    end
    settle();

    if (mismatches == 0)
      $display("tb_scalar_to_rgb_colormap_core OK");
    else
      $display("tb_scalar_to_rgb_colormap_core NOT OK");
    $finish;
  end

endmodule

// ----- scalar_to_rgb_colormap_core.f -----
+incdir+hw/rtl
hw/rtl/stc_pkg.sv
hw/rtl/stc_sample_if.sv
hw/rtl/stc_rgb_if.sv
hw/rtl/stc_prep.sv
hw/rtl/stc_div_cell.sv
hw/rtl/stc_segment.sv
hw/rtl/stc_shade.sv
hw/rtl/scalar_to_rgb_colormap_core.sv
hw/rtl/stc_checker.sv
test/stc_colour_checker.sv
test/tb_scalar_to_rgb_colormap_core.sv
